// ===== sv/led_matrix_scan_flasher_top_assert.svh =====
// Assertion macros for the LED matrix scanner and flasher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LED_MATRIX_SCAN_FLASHER_TOP_ASSERT_SVH
`define LED_MATRIX_SCAN_FLASHER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LMSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmsf assertion failed");

// Next-cycle implication.
`define LMSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmsf assertion failed");

`else

`define LMSF_ASSERT_IMP(lbl, ante, cons)
`define LMSF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/lmsf_pkg.sv =====
`default_nettype none
package lmsf_pkg;

  // Default sizes of the block.
  localparam int LMSF_MATRICES    = 2;
  localparam int LMSF_MAX_SINKS   = 8;
  localparam int LMSF_MAX_SOURCES = 8;
  localparam int LMSF_MAX_LEDS    = 64;

  // Line vectors and per-matrix registers always exist for two matrices.
  localparam int LMSF_MAT_SLOTS = 2;
  localparam int LMSF_CNT_W     = 8;

  // Configuration port.
  localparam int LMSF_CFG_IDX_W  = 3;
  localparam int LMSF_CFG_DATA_W = 7;

  localparam logic [LMSF_CFG_IDX_W-1:0] CFG_SINKS_A   = 3'd0;
  localparam logic [LMSF_CFG_IDX_W-1:0] CFG_SOURCES_A = 3'd1;
  localparam logic [LMSF_CFG_IDX_W-1:0] CFG_LEDS_A    = 3'd2;
  localparam logic [LMSF_CFG_IDX_W-1:0] CFG_SINKS_B   = 3'd3;
  localparam logic [LMSF_CFG_IDX_W-1:0] CFG_SOURCES_B = 3'd4;
  localparam logic [LMSF_CFG_IDX_W-1:0] CFG_LEDS_B    = 3'd5;

  // Item kinds.
  localparam logic [2:0] KIND_SET_LED   = 3'd0;
  localparam logic [2:0] KIND_ARM_FLASH = 3'd1;
  localparam logic [2:0] KIND_WRITE_MAP = 3'd2;
  localparam logic [2:0] KIND_SCAN_TICK = 3'd3;
  localparam logic [2:0] KIND_FLASH     = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic       matrix;
    logic [5:0] led;
    logic       level;
    logic [7:0] flash_count;
    logic [2:0] source;
    logic [2:0] sink;
  } lmsf_in_t;

  typedef struct packed {
    logic [7:0] source_levels_a;
    logic [7:0] sink_levels_a;
    logic [7:0] source_levels_b;
    logic [7:0] sink_levels_b;
  } lmsf_out_t;

  // Clamped counts of one matrix.
  typedef struct packed {
    logic [3:0] nsinks;
    logic [3:0] nsources;
    logic [6:0] nleds;
  } lmsf_counts_t;

endpackage
`default_nettype wire

// ===== sv/lmsf_cfg.sv =====
`default_nettype none
module lmsf_cfg
  import lmsf_pkg::*;
#(
  parameter int MAX_SINKS   = LMSF_MAX_SINKS,
  parameter int MAX_SOURCES = LMSF_MAX_SOURCES,
  parameter int MAX_LEDS    = LMSF_MAX_LEDS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [LMSF_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [LMSF_CFG_DATA_W-1:0] cfg_data,
  output lmsf_counts_t                    counts [LMSF_MAT_SLOTS]
);

  logic [3:0] sinks_r   [LMSF_MAT_SLOTS];
  logic [3:0] sources_r [LMSF_MAT_SLOTS];
  logic [6:0] leds_r    [LMSF_MAT_SLOTS];

  // Register file; indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < LMSF_MAT_SLOTS; m++) begin
        sinks_r[m]   <= 4'd8;
        sources_r[m] <= 4'd8;
        leds_r[m]    <= 7'd64;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SINKS_A:   sinks_r[0]   <= cfg_data[3:0];
        CFG_SOURCES_A: sources_r[0] <= cfg_data[3:0];
        CFG_LEDS_A:    leds_r[0]    <= cfg_data;
        CFG_SINKS_B:   sinks_r[1]   <= cfg_data[3:0];
        CFG_SOURCES_B: sources_r[1] <= cfg_data[3:0];
        CFG_LEDS_B:    leds_r[1]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the counts to what the hardware was built for.
  always_comb begin
    for (int m = 0; m < LMSF_MAT_SLOTS; m++) begin
      if (sinks_r[m] == 4'd0) begin
        counts[m].nsinks = 4'd1;
      end else if (int'(sinks_r[m]) > MAX_SINKS) begin
        counts[m].nsinks = 4'(MAX_SINKS);
      end else begin
        counts[m].nsinks = sinks_r[m];
      end
      if (int'(sources_r[m]) > MAX_SOURCES) begin
        counts[m].nsources = 4'(MAX_SOURCES);
      end else begin
        counts[m].nsources = sources_r[m];
      end
      if (int'(leds_r[m]) > MAX_LEDS) begin
        counts[m].nleds = 7'(MAX_LEDS);
      end else begin
        counts[m].nleds = leds_r[m];
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/led_matrix_scan_flasher_top.sv =====
// Channel   Direction  Payload     Handshake
// in        input      lmsf_in_t   in_valid / in_ready
// out       output     lmsf_out_t  out_valid / out_ready
// cfg       input      index,data  cfg_we (no wait)
//
// One item at a time. Set and arm items with a valid address read the LED word in ST_IDLE
// and write it back in ST_RMW; map writes and unused kinds go straight to ST_FINISH.
// A scan tick steps each matrix through ST_SC_START, then ST_SC_MAP, ST_SC_LED and
// ST_SC_UPD for each source (the map read followed by the LED memory read), then
// ST_SC_END. A flash tick reads one LED per cycle through the read port of the LED memory.
// Reset is synchronous; LED states read as zero through valid bits, so there is no
// clearing pass. A stalled result holds in the output register.
`default_nettype none
`include "led_matrix_scan_flasher_top_assert.svh"
module led_matrix_scan_flasher_top
  import lmsf_pkg::*;
#(
  parameter int MATRICES    = LMSF_MATRICES,
  parameter int MAX_SINKS   = LMSF_MAX_SINKS,
  parameter int MAX_SOURCES = LMSF_MAX_SOURCES,
  parameter int MAX_LEDS    = LMSF_MAX_LEDS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [LMSF_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [LMSF_CFG_DATA_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire lmsf_in_t                   in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lmsf_out_t                       out_data
);

  localparam int LW        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LED_DEPTH = MATRICES * MAX_LEDS;
  localparam int LAW       = (LED_DEPTH > 1) ? $clog2(LED_DEPTH) : 1;
  localparam int MAP_DEPTH = MATRICES * MAX_SOURCES * MAX_SINKS;
  localparam int MAW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int WW        = LMSF_CNT_W + 1;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RMW      = 4'd1;
  localparam logic [3:0] ST_SC_START = 4'd2;
  localparam logic [3:0] ST_SC_MAP   = 4'd3;
  localparam logic [3:0] ST_SC_LED   = 4'd4;
  localparam logic [3:0] ST_SC_UPD   = 4'd5;
  localparam logic [3:0] ST_SC_END   = 4'd6;
  localparam logic [3:0] ST_FL_RUN   = 4'd7;
  localparam logic [3:0] ST_FINISH   = 4'd8;

  localparam logic LAST_MAT = 1'(MATRICES - 1);

  function automatic logic [LAW-1:0] led_addr(input logic m, input logic [LW-1:0] l);
    return LAW'(int'(m) * MAX_LEDS + int'(l));
  endfunction

  function automatic logic [MAW-1:0] map_addr(input logic m, input logic [2:0] s,
                                              input logic [2:0] k);
    return MAW'((int'(m) * MAX_SOURCES + int'(s)) * MAX_SINKS + int'(k));
  endfunction

  function automatic logic addr_ok(input lmsf_in_t it);
    return (int'(it.matrix) < MATRICES) && (int'(it.led) < MAX_LEDS);
  endfunction

  // Wrap the incremented sink; the old sink may lie beyond a reduced count.
  function automatic logic [2:0] next_sink(input logic [2:0] a, input logic [3:0] n);
    logic [3:0] v;
    v = {1'b0, a} + 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (v >= n) v = v - n;
    end
    return v[2:0];
  endfunction

  // One flash step on an LED word {lamp, count}.
  function automatic logic [WW-1:0] flash_upd(input logic [WW-1:0] w);
    logic                  lamp;
    logic [LMSF_CNT_W-1:0] c;
    lamp = w[WW-1];
    c    = w[LMSF_CNT_W-1:0];
    if (c != '0) begin
      lamp = ~lamp;
      if (!lamp) c = c - LMSF_CNT_W'(1);
    end
    return {lamp, c};
  endfunction

  lmsf_counts_t cnt [LMSF_MAT_SLOTS];

  lmsf_cfg #(
    .MAX_SINKS  (MAX_SINKS),
    .MAX_SOURCES(MAX_SOURCES),
    .MAX_LEDS   (MAX_LEDS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .counts   (cnt)
  );

  // Control and payload registers.
  logic [3:0] state_r, state_nxt;
  lmsf_in_t   item_r, item_nxt;
  logic       mat_r, mat_nxt;
  logic [3:0] src_r, src_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic       any_r, any_nxt;
  logic [2:0] sk_r, sk_nxt;
  logic       flv_r, flv_nxt;
  logic       out_valid_r, out_valid_nxt;
  lmsf_out_t  out_data_r, out_data_nxt;
  logic [2:0] active_r  [LMSF_MAT_SLOTS];
  logic [2:0] active_nxt [LMSF_MAT_SLOTS];
  logic [7:0] src_drv_r [LMSF_MAT_SLOTS];
  logic [7:0] src_drv_nxt [LMSF_MAT_SLOTS];
  logic [7:0] snk_drv_r [LMSF_MAT_SLOTS];
  logic [7:0] snk_drv_nxt [LMSF_MAT_SLOTS];

  // LED memory {lamp, count} with valid bits, and the position map.
  logic [WW-1:0]        led_mem [LED_DEPTH];
  logic [LED_DEPTH-1:0] valid_r;
  logic                 led_rd_en, led_wr_en;
  logic [LAW-1:0]       led_rd_addr, led_wr_addr, led_qa_r;
  logic [WW-1:0]        led_wr_data, led_q_r, led_eff;
  logic [LW-1:0]        map_mem [MAP_DEPTH];
  logic                 map_rd_en, map_wr_en;
  logic [MAW-1:0]       map_rd_addr, map_wr_addr;
  logic [LW-1:0]        map_wr_data, map_q_r;
  logic                 load_out;

  // An entry never written since reset reads as zero.
  assign led_eff  = valid_r[led_qa_r] ? led_q_r : '0;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    mat_nxt     = mat_r;
    src_nxt     = src_r;
    idx_nxt     = idx_r;
    any_nxt     = any_r;
    sk_nxt      = sk_r;
    flv_nxt     = flv_r;
    active_nxt  = active_r;
    src_drv_nxt = src_drv_r;
    snk_drv_nxt = snk_drv_r;
    led_rd_en   = 1'b0;
    led_rd_addr = '0;
    map_rd_en   = 1'b0;
    map_rd_addr = '0;
    map_wr_en   = 1'b0;
    map_wr_addr = '0;
    map_wr_data = '0;
    load_out    = 1'b0;

    // Write-back of the flash pipeline, in the cycle after its read.
    led_wr_en   = flv_r;
    led_wr_addr = led_qa_r;
    led_wr_data = flash_upd(led_eff);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          mat_nxt  = 1'b0;
          idx_nxt  = '0;
          case (in_data.kind)
            KIND_SET_LED, KIND_ARM_FLASH: begin
              if (addr_ok(in_data)) begin
                led_rd_en   = 1'b1;
                led_rd_addr = led_addr(in_data.matrix, LW'(in_data.led));
                state_nxt   = ST_RMW;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            KIND_WRITE_MAP: begin
              if (addr_ok(in_data) && (int'(in_data.source) < MAX_SOURCES) &&
                  (int'(in_data.sink) < MAX_SINKS)) begin
                map_wr_en   = 1'b1;
                map_wr_addr = map_addr(in_data.matrix, in_data.source, in_data.sink);
                map_wr_data = LW'(in_data.led);
              end
              state_nxt = ST_FINISH;
            end
            KIND_SCAN_TICK: state_nxt = ST_SC_START;
            KIND_FLASH:     state_nxt = ST_FL_RUN;
            default:        state_nxt = ST_FINISH;
          endcase
        end
      end

      ST_RMW: begin
        led_wr_en   = 1'b1;
        led_wr_addr = led_qa_r;
        if (item_r.kind == KIND_SET_LED) begin
          led_wr_data = {item_r.level, led_eff[LMSF_CNT_W-1:0]};
        end else begin
          led_wr_data = {led_eff[WW-1], item_r.flash_count};
        end
        state_nxt = ST_FINISH;
      end

      // Release the old sink and step to the next one.
      ST_SC_START: begin
        snk_drv_nxt[mat_r][active_r[mat_r]] = 1'b1;
        sk_nxt  = next_sink(active_r[mat_r], cnt[mat_r].nsinks);
        active_nxt[mat_r] = sk_nxt;
        src_nxt = '0;
        any_nxt = 1'b0;
        state_nxt = (cnt[mat_r].nsources == 4'd0) ? ST_SC_END : ST_SC_MAP;
      end

      ST_SC_MAP: begin
        map_rd_en   = 1'b1;
        map_rd_addr = map_addr(mat_r, src_r[2:0], sk_r);
        state_nxt   = ST_SC_LED;
      end

      ST_SC_LED: begin
        led_rd_en   = 1'b1;
        led_rd_addr = led_addr(mat_r, map_q_r);
        state_nxt   = ST_SC_UPD;
      end

      ST_SC_UPD: begin
        src_drv_nxt[mat_r][src_r[2:0]] = led_eff[WW-1];
        any_nxt = any_r | led_eff[WW-1];
        src_nxt = src_r + 4'd1;
        state_nxt = ((src_r + 4'd1) < cnt[mat_r].nsources) ? ST_SC_MAP : ST_SC_END;
      end

      ST_SC_END: begin
        snk_drv_nxt[mat_r][sk_r] = ~any_r;
        if (mat_r == LAST_MAT) begin
          state_nxt = ST_FINISH;
        end else begin
          mat_nxt   = 1'b1;
          state_nxt = ST_SC_START;
        end
      end

      // One LED read per cycle; each write lands in the cycle after its read.
      ST_FL_RUN: begin
        if (idx_r < cnt[mat_r].nleds) begin
          led_rd_en   = 1'b1;
          led_rd_addr = led_addr(mat_r, LW'(idx_r));
          idx_nxt     = idx_r + 7'd1;
          flv_nxt     = 1'b1;
        end else begin
          flv_nxt = 1'b0;
          if (mat_r == LAST_MAT) begin
            state_nxt = ST_FINISH;
          end else begin
            mat_nxt = 1'b1;
            idx_nxt = '0;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_data_nxt = out_data_r;
    if (load_out) begin
      out_data_nxt.source_levels_a = src_drv_r[0];
      out_data_nxt.sink_levels_a   = snk_drv_r[0];
      out_data_nxt.source_levels_b = src_drv_r[1];
      out_data_nxt.sink_levels_b   = snk_drv_r[1];
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state. Drive entries of a missing matrix stay high from reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      for (int m = 0; m < LMSF_MAT_SLOTS; m++) begin
        active_r[m]  <= 3'd0;
        src_drv_r[m] <= 8'hFF;
        snk_drv_r[m] <= 8'hFF;
      end
    end else begin
      state_r     <= state_nxt;
      flv_r       <= flv_nxt;
      out_valid_r <= out_valid_nxt;
      if (led_wr_en) valid_r[led_wr_addr] <= 1'b1;
      for (int m = 0; m < LMSF_MAT_SLOTS; m++) begin
        if (m < MATRICES) begin
          active_r[m]  <= active_nxt[m];
          src_drv_r[m] <= src_drv_nxt[m];
          snk_drv_r[m] <= snk_drv_nxt[m];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    mat_r      <= mat_nxt;
    src_r      <= src_nxt;
    idx_r      <= idx_nxt;
    any_r      <= any_nxt;
    sk_r       <= sk_nxt;
    out_data_r <= out_data_nxt;
  end

  // LED memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (led_wr_en) led_mem[led_wr_addr] <= led_wr_data;
    if (led_rd_en) begin
      led_q_r  <= led_mem[led_rd_addr];
      led_qa_r <= led_rd_addr;
    end
  end

  // Position map memory.
  always_ff @(posedge clk) begin
    if (map_wr_en) map_mem[map_wr_addr] <= map_wr_data;
    if (map_rd_en) map_q_r <= map_mem[map_rd_addr];
  end

  // An accepted item always starts work.
  `LMSF_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE)
  // No flash write-back is pending once the block takes items again.
  `LMSF_ASSERT_IMP(a_idle_no_wb, in_ready, !flv_r)
  // The LED memory is never read and written at the same entry in one cycle.
  `LMSF_ASSERT_IMP(a_no_rw_clash, led_wr_en && led_rd_en, led_wr_addr != led_rd_addr)
  // A result appears only at the end of an item.
  `LMSF_ASSERT_IMP(a_out_from_finish, $rose(out_valid_r), $past(state_r) == ST_FINISH)

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lmsf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 110;
  localparam int RANDOM_PHASES = 8;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [LMSF_CFG_IDX_W-1:0]  cfg_index;
  logic [LMSF_CFG_DATA_W-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  lmsf_in_t                   in_data;
  logic                       out_valid;
  logic                       out_ready;
  lmsf_out_t                  out_data;

  led_matrix_scan_flasher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the matrix state and the count registers.
  logic [LMSF_CFG_DATA_W-1:0] count_reg [CFG_LEDS_B + 1];
  logic [2:0] cur_sink  [LMSF_MAT_SLOTS];
  logic       lit       [LMSF_MAT_SLOTS][LMSF_MAX_LEDS];
  logic [7:0] flashes   [LMSF_MAT_SLOTS][LMSF_MAX_LEDS];
  logic [5:0] led_at    [LMSF_MAT_SLOTS][LMSF_MAX_SOURCES][LMSF_MAX_SINKS];
  logic [7:0] src_lines [LMSF_MAT_SLOTS];
  logic [7:0] snk_lines [LMSF_MAT_SLOTS];

  lmsf_out_t levels_due [$];
  int        mismatch_count;
  bit        idle_on;
  int        out_hold_cycles;
  int        rx_stall_left;

  always #1 clk = ~clk;

  // Apply one item to the shadow state and return the line levels it leaves.
  function automatic lmsf_out_t next_line_levels(lmsf_in_t it);
    int        nsk;
    int        nsrc;
    int        nled;
    int        sk;
    logic      any;
    lmsf_out_t lv;
    case (it.kind)
      KIND_SET_LED: begin
        if (it.matrix < LMSF_MATRICES) lit[it.matrix][it.led] = it.level;
      end
      KIND_ARM_FLASH: begin
        if (it.matrix < LMSF_MATRICES) flashes[it.matrix][it.led] = it.flash_count;
      end
      KIND_WRITE_MAP: begin
        if (it.matrix < LMSF_MATRICES) led_at[it.matrix][it.source][it.sink] = it.led;
      end
      KIND_SCAN_TICK: begin
        for (int m = 0; m < LMSF_MATRICES; m++) begin
          nsk = int'(count_reg[CFG_SINKS_A + 3 * m]);
          if (nsk < 1) nsk = 1;
          if (nsk > LMSF_MAX_SINKS) nsk = LMSF_MAX_SINKS;
          nsrc = int'(count_reg[CFG_SOURCES_A + 3 * m]);
          if (nsrc > LMSF_MAX_SOURCES) nsrc = LMSF_MAX_SOURCES;
          // Release the old sink, then step to the next one with wrap.
          snk_lines[m][cur_sink[m]] = 1'b1;
          sk = (int'(cur_sink[m]) + 1) % nsk;
          cur_sink[m] = 3'(sk);
          any = 1'b0;
          for (int s = 0; s < nsrc; s++) begin
            if (lit[m][led_at[m][s][sk]]) begin
              any = 1'b1;
              src_lines[m][s] = 1'b1;
            end else begin
              src_lines[m][s] = 1'b0;
            end
          end
          snk_lines[m][sk] = !any;
        end
      end
      KIND_FLASH: begin
        for (int m = 0; m < LMSF_MATRICES; m++) begin
          nled = int'(count_reg[CFG_LEDS_A + 3 * m]);
          if (nled > LMSF_MAX_LEDS) nled = LMSF_MAX_LEDS;
          for (int i = 0; i < nled; i++) begin
            if (flashes[m][i] != 8'd0) begin
              lit[m][i] = !lit[m][i];
              // A flash is used up each time the LED goes dark.
              if (!lit[m][i]) flashes[m][i] = flashes[m][i] - 8'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    lv.source_levels_a = src_lines[0];
    lv.sink_levels_a   = snk_lines[0];
    lv.source_levels_b = (LMSF_MATRICES > 1) ? src_lines[1] : 8'hFF;
    lv.sink_levels_b   = (LMSF_MATRICES > 1) ? snk_lines[1] : 8'hFF;
    return lv;
  endfunction

  // An item of the given kind with every other field random.
  function automatic lmsf_in_t make_item(logic [2:0] kind);
    logic [$bits(lmsf_in_t)-1:0] raw;
    lmsf_in_t                    it;
    raw = $bits(lmsf_in_t)'($urandom);
    it = raw;
    it.kind = kind;
    return it;
  endfunction

  // A random item, weighted toward scans and LED updates.
  function automatic lmsf_in_t random_item();
    int       r;
    int       c;
    lmsf_in_t it;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      it = make_item(KIND_SET_LED);
    end else if (r < 40) begin
      it = make_item(KIND_ARM_FLASH);
      c = $urandom_range(0, 9);
      if (c == 0) it.flash_count = 8'hFF;
      else if (c > 1) it.flash_count = 8'($urandom_range(0, 4));
    end else if (r < 50) begin
      it = make_item(KIND_WRITE_MAP);
    end else if (r < 80) begin
      it = make_item(KIND_SCAN_TICK);
    end else if (r < 95) begin
      it = make_item(KIND_FLASH);
    end else begin
      it = make_item(KIND_FLASH + 3'($urandom_range(1, 3)));
    end
    return it;
  endfunction

  // Offer one item, with an optional idle burst first, and wait for it to be taken.
  task automatic send_item(lmsf_in_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    levels_due.push_back(next_line_levels(it));
  endtask

  // Stop offering items until every pending result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
  endtask

  task automatic write_reg(logic [LMSF_CFG_IDX_W-1:0] idx, logic [LMSF_CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    // Sink and source counts are four bits wide; indexes past the last register do nothing.
    if (idx <= CFG_LEDS_B) begin
      if (idx == CFG_LEDS_A || idx == CFG_LEDS_B) count_reg[idx] = val;
      else count_reg[idx] = val & 7'h0F;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_counts(logic [6:0] sk_a, logic [6:0] src_a, logic [6:0] led_a,
                            logic [6:0] sk_b, logic [6:0] src_b, logic [6:0] led_b);
    wait_drained();
    write_reg(CFG_SINKS_A, sk_a);
    write_reg(CFG_SOURCES_A, src_a);
    write_reg(CFG_LEDS_A, led_a);
    write_reg(CFG_SINKS_B, sk_b);
    write_reg(CFG_SOURCES_B, src_b);
    write_reg(CFG_LEDS_B, led_b);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  // Give every crossing of both matrices a map entry before any scan reads it.
  task automatic test_map_fill();
    lmsf_in_t it;
    for (int m = 0; m < LMSF_MATRICES; m++) begin
      for (int s = 0; s < LMSF_MAX_SOURCES; s++) begin
        for (int k = 0; k < LMSF_MAX_SINKS; k++) begin
          it = make_item(KIND_WRITE_MAP);
          it.matrix = 1'(m);
          it.source = 3'(s);
          it.sink   = 3'(k);
          send_item(it);
        end
      end
    end
  endtask

  // Field extremes, every kind, and the unused kinds.
  task automatic test_directed();
    lmsf_in_t it;
    it = make_item(KIND_SET_LED);
    it.matrix = 1'b0; it.led = 6'd0; it.level = 1'b1;
    send_item(it);
    it = make_item(KIND_SET_LED);
    it.matrix = 1'b1; it.led = 6'd63; it.level = 1'b1;
    send_item(it);
    it = make_item(KIND_SET_LED);
    it.matrix = 1'b1; it.led = 6'd5; it.level = 1'b0;
    send_item(it);
    it = make_item(KIND_ARM_FLASH);
    it.matrix = 1'b0; it.led = 6'd0; it.flash_count = 8'd1;
    send_item(it);
    it = make_item(KIND_ARM_FLASH);
    it.matrix = 1'b1; it.led = 6'd63; it.flash_count = 8'd255;
    send_item(it);
    it = make_item(KIND_ARM_FLASH);
    it.matrix = 1'b1; it.led = 6'd62; it.flash_count = 8'd0;
    send_item(it);
    it = make_item(KIND_WRITE_MAP);
    it.matrix = 1'b0; it.source = 3'd7; it.sink = 3'd7; it.led = 6'd63;
    send_item(it);
    it = make_item(KIND_WRITE_MAP);
    it.matrix = 1'b1; it.source = 3'd0; it.sink = 3'd0; it.led = 6'd0;
    send_item(it);
    it = make_item(KIND_WRITE_MAP);
    it.matrix = 1'b1; it.source = 3'd7; it.sink = 3'd0; it.led = 6'd63;
    send_item(it);
    // One full scan cycle plus the wrap back to the first sink.
    for (int i = 0; i < LMSF_MAX_SINKS + 1; i++) send_item(make_item(KIND_SCAN_TICK));
    for (int i = 0; i < 3; i++) send_item(make_item(KIND_FLASH));
    for (int k = 1; k <= 3; k++) send_item(make_item(KIND_FLASH + 3'(k)));
  endtask

  // Count registers at zero, one, full and past their limits.
  task automatic test_count_extremes();
    set_counts(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    send_random(30);
    set_counts(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
    send_random(30);
    set_counts(7'd15, 7'd15, 7'd127, 7'd15, 7'd15, 7'd127);
    send_random(30);
    set_counts(7'h7F, 7'h78, 7'd65, 7'h79, 7'h7F, 7'd64);
    send_random(30);
    // Shrink the sink count while the active sink sits above it.
    set_counts(7'd8, 7'd8, 7'd64, 7'd8, 7'd8, 7'd64);
    for (int i = 0; i < 6; i++) send_item(make_item(KIND_SCAN_TICK));
    set_counts(7'd3, 7'd8, 7'd64, 7'd2, 7'd5, 7'd64);
    for (int i = 0; i < 4; i++) send_item(make_item(KIND_SCAN_TICK));
    // Writes past the last register must leave the counts alone.
    wait_drained();
    write_reg(CFG_LEDS_B + 3'd1, 7'h55);
    write_reg(CFG_LEDS_B + 3'd2, 7'h2A);
    send_random(20);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_hold();
    bit saved_idle;
    saved_idle = idle_on;
    idle_on = 1'b0;
    out_hold_cycles = 400;
    send_random(30);
    idle_on = saved_idle;
  endtask

  // The sender stops until the block has emptied, then resumes.
  task automatic test_sender_pause();
    send_random(10);
    wait_drained();
    send_random(10);
  endtask

  // Random phases, each under its own count settings and idling mode.
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 4) == 0)
        set_counts(7'($urandom), 7'($urandom), 7'($urandom),
                   7'($urandom), 7'($urandom), 7'($urandom));
      else
        set_counts(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                   7'($urandom_range(1, 64)), 7'($urandom_range(1, 8)),
                   7'($urandom_range(1, 8)), 7'($urandom_range(1, 64)));
      idle_on = ($urandom_range(0, 3) != 0);
      send_random(PHASE_ITEMS);
    end
  endtask

  // Back to back traffic on both sides to close the run.
  task automatic test_no_idle();
    set_counts(7'd8, 7'd8, 7'd64, 7'd8, 7'd8, 7'd64);
    idle_on = 1'b0;
    send_random(PHASE_ITEMS);
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (out_hold_cycles > 0) begin
        out_ready <= 1'b0;
        out_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        rx_stall_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest predicted line levels.
  always @(posedge clk) begin
    lmsf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        if (mismatch_count < 10) $display("result with nothing pending: %h", out_data);
        mismatch_count++;
      end else begin
        want = levels_due.pop_front();
        if (want.source_levels_a !== out_data.source_levels_a ||
            want.sink_levels_a   !== out_data.sink_levels_a ||
            want.source_levels_b !== out_data.source_levels_b ||
            want.sink_levels_b   !== out_data.sink_levels_b) begin
          if (mismatch_count < 10)
            $display("result differs: exp src_a %h snk_a %h src_b %h snk_b %h, got %h %h %h %h",
                     want.source_levels_a, want.sink_levels_a, want.source_levels_b,
                     want.sink_levels_b, out_data.source_levels_a, out_data.sink_levels_a,
                     out_data.source_levels_b, out_data.sink_levels_b);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("led_matrix_scan_flasher_top: mismatch");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    idle_on         = 1'b1;
    out_hold_cycles = 0;
    rx_stall_left   = 0;
    mismatch_count  = 0;
    // Shadow state as it stands after reset.
    count_reg[CFG_SINKS_A]   = 7'd8;
    count_reg[CFG_SOURCES_A] = 7'd8;
    count_reg[CFG_LEDS_A]    = 7'd64;
    count_reg[CFG_SINKS_B]   = 7'd8;
    count_reg[CFG_SOURCES_B] = 7'd8;
    count_reg[CFG_LEDS_B]    = 7'd64;
    for (int m = 0; m < LMSF_MAT_SLOTS; m++) begin
      cur_sink[m]  = 3'd0;
      src_lines[m] = 8'hFF;
      snk_lines[m] = 8'hFF;
      for (int i = 0; i < LMSF_MAX_LEDS; i++) begin
        lit[m][i]     = 1'b0;
        flashes[m][i] = 8'd0;
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_map_fill();
    test_directed();
    test_count_extremes();
    test_output_hold();
    test_sender_pause();
    test_random_phases();
    test_no_idle();

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && levels_due.size() == 0)
      $display("led_matrix_scan_flasher_top: match");
    else
      $display("led_matrix_scan_flasher_top: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lmsf_pkg.sv
sv/lmsf_cfg.sv
sv/led_matrix_scan_flasher_top.sv
sim/tb.sv
